// ===== hw/rtl/mmsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmsl_pkg;

    // Default word format, Q16.16
    localparam int unsigned WORD_WIDTH_DEF    = 32;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // Register file
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SPACING_W  = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_VALUE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VALUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SPACING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SPACING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_GRID   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_WAY     = 3'd6;

    // 1.0 in Q16.16: reset of alpha and both spacings
    localparam logic [SPACING_W-1:0] ONE_Q16 = 31'd65536;

    // Divider operand select
    localparam logic DIV_SEL_LEFT  = 1'b0;
    localparam logic DIV_SEL_RIGHT = 1'b1;

    // Scaling operand select
    localparam logic SCL_SEL_A = 1'b0;
    localparam logic SCL_SEL_B = 1'b1;

    // Width of the config data bus
    function automatic int f_cfg_w(input int w);
        return (w > 31) ? w : 31;
    endfunction

    // Width of a signed span: edge difference plus a 31-bit spacing
    function automatic int f_span_w(input int w);
        return ((w > 31) ? w : 31) + 2;
    endfunction

    // Width of the divisor magnitude, capped at 64 bits
    function automatic int f_den_w(input int w);
        return (f_span_w(w) - 1 > 64) ? 64 : f_span_w(w) - 1;
    endfunction

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel;
        logic cap_lq;
        logic cap_rq;
        logic scale_start;
        logic scale_sel;
        logic mm_first;
        logic mm_old;
        logic emit;
        logic phase;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic three_way;
        logic div_done;
        logic scale_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/mmsl_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmsl_divider
    import mmsl_pkg::*;
#(
    parameter int unsigned WORD_WIDTH    = WORD_WIDTH_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [WORD_WIDTH:0]               i_num_mag,
    input  logic                              i_num_neg,
    input  logic                              i_den_neg,
    input  logic [f_den_w(WORD_WIDTH)-1:0]    i_den,
    output logic                              o_done,
    output logic [WORD_WIDTH-1:0]             o_quot
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int DW   = f_den_w(WORD_WIDTH);
    localparam int NW   = W + 1 + F;
    localparam int TW   = F + 1;
    localparam int CMPW = (TW > DW) ? TW : DW;
    localparam int CNTW = $clog2(W + 1);
    localparam bit HAS_BIG = (W >= 64);
    localparam logic [W-1:0] SIGN_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_MAX  = ~SIGN_MIN;

    logic            r_busy, r_fin, r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem, r_den;
    logic [W-1:0]    r_low, r_q, r_quot;
    logic            r_neg;

    logic [NW-1:0]   num_full;
    logic [TW-1:0]   top;
    logic [CMPW-1:0] top_ext, den_ext;
    logic            neg, top_ge, big;
    logic [DW:0]     trial;
    logic            step_ge;
    logic [DW-1:0]   n_rem;
    logic [W-1:0]    lim, q_sat;

    // Numerator shifted up by the fraction bits; the part above W bits decides
    // overflow in one compare, so only W quotient bits are developed.
    assign num_full = {i_num_mag, {F{1'b0}}};
    assign top      = num_full[NW-1:W];
    assign top_ext  = CMPW'(top);
    assign den_ext  = CMPW'(i_den);
    assign top_ge   = top_ext >= den_ext;
    assign neg      = i_num_neg ^ i_den_neg;
    assign big      = HAS_BIG && i_num_mag[W];

    assign trial   = {r_rem, r_low[W-1]};
    assign step_ge = trial >= {1'b0, r_den};
    assign n_rem   = step_ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];

    assign lim   = r_neg ? SIGN_MIN : POS_MAX;
    assign q_sat = (r_q > lim) ? lim : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_num_mag == '0 || i_den == '0 || big || top_ge) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNTW'(W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= top_ext[DW-1:0];
            r_low <= num_full[W-1:0];
            r_den <= i_den;
            r_neg <= neg;
            r_q   <= '0;
            if (i_num_mag == '0) begin
                r_quot <= '0;
            end else if (i_den == '0) begin
                r_quot <= i_num_neg ? SIGN_MIN : POS_MAX;
            end else begin
                r_quot <= neg ? SIGN_MIN : POS_MAX;
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[W-2:0], 1'b0};
            r_q   <= {r_q[W-2:0], step_ge};
        end else if (r_fin) begin
            r_quot <= r_neg ? (~q_sat + 1'b1) : q_sat;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== hw/rtl/mmsl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmsl_datapath
    import mmsl_pkg::*;
#(
    parameter int unsigned WORD_WIDTH    = WORD_WIDTH_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [f_cfg_w(WORD_WIDTH)-1:0]  i_cfg_data,
    input  logic [WORD_WIDTH-1:0]           i_cell_value,
    input  logic [WORD_WIDTH-1:0]           i_edge_left,
    input  logic [WORD_WIDTH-1:0]           i_edge_right,
    input  logic [WORD_WIDTH-1:0]           i_old_slope,
    input  logic                            i_last_cell,
    input  t_cmd                            i_cmd,
    output t_status                         o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [WORD_WIDTH-1:0]           o_out_slope,
    output logic                            o_out_final_result
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int SW  = f_span_w(WORD_WIDTH);
    localparam int DW  = f_den_w(WORD_WIDTH);
    localparam int CH  = (W + 31) / 32;
    localparam int MW  = CH * 32;
    localparam int AW  = MW + SPACING_W;
    localparam int SCW = $clog2(CH + 1);
    localparam logic [W-1:0] SIGN_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_MAX  = ~SIGN_MIN;

    // Configuration
    logic [SPACING_W-1:0] r_alpha, r_left_sp, r_right_sp;
    logic [W-1:0]         r_left_value, r_right_value;
    logic                 r_moving, r_three_way;

    // Current item and sweep state
    logic [W-1:0] r_v, r_xl, r_xr, r_old;
    logic         r_last;
    logic         r_have_prev;
    logic [W-1:0] r_prev_v, r_prev_xl, r_prev_lq, r_prev_old;
    logic [W-1:0] r_lq, r_rq, r_sa, r_sb, r_mm;

    // Output register
    logic         r_out_valid, r_out_final;
    logic [W-1:0] r_out_slope;

    // Scaling unit
    logic            r_scl_busy, r_scl_fin, r_scl_neg, r_scl_sel;
    logic [SCW-1:0]  r_scl_cnt;
    logic [MW-1:0]   r_scl_mag;
    logic [AW-1:0]   r_acc;

    function automatic logic [W-1:0] f_minmod(input logic [W-1:0] a, input logic [W-1:0] b);
        logic         a_neg, b_neg, a_pos, b_pos;
        logic [W-1:0] ma, mb;
        a_neg = a[W-1];
        b_neg = b[W-1];
        a_pos = !a_neg && (a != '0);
        b_pos = !b_neg && (b != '0);
        ma    = a_neg ? (~a + 1'b1) : a;
        mb    = b_neg ? (~b + 1'b1) : b;
        if ((a_pos && b_pos) || (a_neg && b_neg)) begin
            return (ma <= mb) ? a : b;
        end
        return '0;
    endfunction

    // ---------------- divider operands ----------------
    logic [W-1:0]         num_hi, num_lo;
    logic [W:0]           num, num_mag;
    logic                 num_neg;
    logic [SPACING_W-1:0] spacing;
    logic [SW-1:0]        xr_e, xl_e, pxl_e, span, span_mag;
    logic [DW-1:0]        den;
    logic                 den_neg;
    logic                 div_done;
    logic [W-1:0]         div_quot;
    logic                 left_sel;

    assign left_sel = (i_cmd.div_sel == DIV_SEL_LEFT);
    assign num_hi   = left_sel ? r_v : r_right_value;
    assign num_lo   = left_sel ? (r_have_prev ? r_prev_v : r_left_value) : r_v;
    assign num      = {num_hi[W-1], num_hi} - {num_lo[W-1], num_lo};
    assign num_neg  = num[W];
    assign num_mag  = num_neg ? (~num + 1'b1) : num;

    assign spacing  = left_sel ? r_left_sp : r_right_sp;
    assign xr_e     = {{(SW-W){r_xr[W-1]}}, r_xr};
    assign xl_e     = {{(SW-W){r_xl[W-1]}}, r_xl};
    assign pxl_e    = {{(SW-W){r_prev_xl[W-1]}}, r_prev_xl};
    assign span     = (left_sel && r_have_prev) ? (xr_e - pxl_e)
                                                : (xr_e - xl_e + SW'(spacing));
    assign span_mag = span[SW-1] ? (~span + 1'b1) : span;
    assign den_neg  = r_moving && span[SW-1];
    // moving grid halves the span; fixed grid divides by the left spacing
    assign den      = r_moving ? span_mag[DW:1] : DW'(r_left_sp);

    mmsl_divider #(
        .WORD_WIDTH    (WORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_num_mag (num_mag),
        .i_num_neg (num_neg),
        .i_den_neg (den_neg),
        .i_den     (den),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // ---------------- limiter operands ----------------
    logic [W-1:0] op_a, op_b, op_o, scl_src, scl_src_mag;
    logic [62:0]  prod;
    logic [AW-1:0] scaled, lim_ext;
    logic [W-1:0] scl_lim, scl_mag_sat, scl_res;
    logic [W-1:0] mm_x, mm_y;

    assign op_a = i_cmd.phase ? r_lq  : r_prev_lq;
    assign op_b = i_cmd.phase ? r_rq  : r_lq;
    assign op_o = i_cmd.phase ? r_old : r_prev_old;

    assign scl_src     = (i_cmd.scale_sel == SCL_SEL_A) ? op_a : op_b;
    assign scl_src_mag = scl_src[W-1] ? (~scl_src + 1'b1) : scl_src;

    // one 32 x 31 partial product a cycle, top chunk first
    assign prod        = r_scl_mag[MW-1 -: 32] * r_alpha;
    assign scaled      = r_acc >> F;
    assign scl_lim     = r_scl_neg ? SIGN_MIN : POS_MAX;
    assign lim_ext     = AW'(scl_lim);
    assign scl_mag_sat = (scaled > lim_ext) ? scl_lim : scaled[W-1:0];
    assign scl_res     = r_scl_neg ? (~scl_mag_sat + 1'b1) : scl_mag_sat;

    assign mm_x = r_three_way ? r_sa : op_a;
    assign mm_y = r_three_way ? r_sb : op_b;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= ONE_Q16;
            r_left_value  <= '0;
            r_right_value <= '0;
            r_left_sp     <= ONE_Q16;
            r_right_sp    <= ONE_Q16;
            r_moving      <= 1'b0;
            r_three_way   <= 1'b0;
            r_have_prev   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_scl_busy    <= 1'b0;
            r_scl_fin     <= 1'b0;
            r_scl_cnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ALPHA:         r_alpha       <= i_cfg_data[SPACING_W-1:0];
                    CFG_LEFT_VALUE:    r_left_value  <= i_cfg_data[W-1:0];
                    CFG_RIGHT_VALUE:   r_right_value <= i_cfg_data[W-1:0];
                    CFG_LEFT_SPACING:  r_left_sp     <= i_cfg_data[SPACING_W-1:0];
                    CFG_RIGHT_SPACING: r_right_sp    <= i_cfg_data[SPACING_W-1:0];
                    CFG_MOVING_GRID:   r_moving      <= i_cfg_data[0];
                    CFG_THREE_WAY:     r_three_way   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.update) begin
                r_have_prev <= !r_last;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_scl_fin <= 1'b0;
            if (i_cmd.scale_start) begin
                r_scl_busy <= 1'b1;
                r_scl_cnt  <= SCW'(CH);
            end else if (r_scl_busy) begin
                r_scl_cnt <= r_scl_cnt - 1'b1;
                if (r_scl_cnt == SCW'(1)) begin
                    r_scl_busy <= 1'b0;
                    r_scl_fin  <= 1'b1;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_cell_value;
            r_xl   <= i_edge_left;
            r_xr   <= i_edge_right;
            r_old  <= i_old_slope;
            r_last <= i_last_cell;
        end
        if (i_cmd.cap_lq) begin
            r_lq <= div_quot;
        end
        if (i_cmd.cap_rq) begin
            r_rq <= div_quot;
        end
        if (i_cmd.update && !r_last) begin
            r_prev_v   <= r_v;
            r_prev_xl  <= r_xl;
            r_prev_lq  <= r_lq;
            r_prev_old <= r_old;
        end
        if (i_cmd.scale_start) begin
            r_scl_mag <= MW'(scl_src_mag);
            r_scl_neg <= scl_src[W-1];
            r_scl_sel <= i_cmd.scale_sel;
            r_acc     <= '0;
        end else if (r_scl_busy) begin
            r_scl_mag <= r_scl_mag << 32;
            r_acc     <= (r_acc << 32) + AW'(prod);
        end
        if (r_scl_fin) begin
            if (r_scl_sel == SCL_SEL_A) begin
                r_sa <= scl_res;
            end else begin
                r_sb <= scl_res;
            end
        end
        if (i_cmd.mm_first) begin
            r_mm <= f_minmod(mm_x, mm_y);
        end else if (i_cmd.mm_old) begin
            r_mm <= f_minmod(r_mm, op_o);
        end
        if (i_cmd.emit) begin
            r_out_slope <= r_mm;
            r_out_final <= i_cmd.phase;
        end
    end

    assign o_status.have_prev  = r_have_prev;
    assign o_status.last       = r_last;
    assign o_status.three_way  = r_three_way;
    assign o_status.div_done   = div_done;
    assign o_status.scale_done = r_scl_fin;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_out_slope        = r_out_slope;
    assign o_out_final_result = r_out_final;

endmodule

`default_nettype wire

// ===== hw/rtl/mmsl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmsl_ctrl
    import mmsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_L    = 4'd1;
    localparam logic [3:0] ST_WAIT_L   = 4'd2;
    localparam logic [3:0] ST_SCL_A    = 4'd3;
    localparam logic [3:0] ST_SCL_A_WT = 4'd4;
    localparam logic [3:0] ST_SCL_B    = 4'd5;
    localparam logic [3:0] ST_SCL_B_WT = 4'd6;
    localparam logic [3:0] ST_MM2      = 4'd7;
    localparam logic [3:0] ST_MM3      = 4'd8;
    localparam logic [3:0] ST_EMIT     = 4'd9;
    localparam logic [3:0] ST_DIV_R    = 4'd10;
    localparam logic [3:0] ST_WAIT_R   = 4'd11;
    localparam logic [3:0] ST_UPDATE   = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_phase, n_phase;
    logic [3:0] limit_entry;

    assign limit_entry = i_status.three_way ? ST_SCL_A : ST_MM2;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = 1'b0;
                    n_state    = ST_DIV_L;
                end
            end
            ST_DIV_L: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_LEFT;
                n_state         = ST_WAIT_L;
            end
            ST_WAIT_L: begin
                if (i_status.div_done) begin
                    o_cmd.cap_lq = 1'b1;
                    if (i_status.have_prev) begin
                        n_state = limit_entry;
                    end else if (i_status.last) begin
                        n_state = ST_DIV_R;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_SCL_A: begin
                o_cmd.scale_start = 1'b1;
                o_cmd.scale_sel   = SCL_SEL_A;
                n_state           = ST_SCL_A_WT;
            end
            ST_SCL_A_WT: begin
                if (i_status.scale_done) begin
                    n_state = ST_SCL_B;
                end
            end
            ST_SCL_B: begin
                o_cmd.scale_start = 1'b1;
                o_cmd.scale_sel   = SCL_SEL_B;
                n_state           = ST_SCL_B_WT;
            end
            ST_SCL_B_WT: begin
                if (i_status.scale_done) begin
                    n_state = ST_MM2;
                end
            end
            ST_MM2: begin
                o_cmd.mm_first = 1'b1;
                n_state        = i_status.three_way ? ST_MM3 : ST_EMIT;
            end
            ST_MM3: begin
                o_cmd.mm_old = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!r_phase && i_status.last) begin
                        n_state = ST_DIV_R;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_DIV_R: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_RIGHT;
                n_state         = ST_WAIT_R;
            end
            ST_WAIT_R: begin
                if (i_status.div_done) begin
                    o_cmd.cap_rq = 1'b1;
                    n_phase      = 1'b1;
                    n_state      = limit_entry;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/minmod_slope_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Minmod slope limiter for a one-dimensional sweep, signed fixed point.
//
// Input channel (i_in_valid / o_in_ready): one grid cell per item, left to
// right, i_last_cell on the final cell. Output channel (o_out_valid /
// i_out_ready): one slope per cell in cell order; the slope of a cell leaves
// when the next cell arrives, so a last cell that has a predecessor yields two
// items, the second with o_out_final_result set. Config channel (i_cfg_valid /
// o_cfg_ready) is always ready; write it only while the block is idle.
//
// One item at a time. Each difference quotient goes through a shared
// restoring divider, one quotient bit a cycle; the divider finishes early
// when the spacing or difference is zero or the quotient is too large for
// the word. A cell with a predecessor runs one quotient, the limiting and
// the emit before the next accept; the last cell adds a second quotient.
// Three-way mode adds two alpha scalings, each one partial product per
// 32-bit chunk, and one minmod step.
//
// Reset (synchronous, active low) restores the register defaults and starts a
// new sweep. A stalled receiver holds the output register; the block stops
// only when its next result has nowhere to go.

module minmod_slope_limiter
    import mmsl_pkg::*;
#(
    parameter int unsigned WORD_WIDTH    = WORD_WIDTH_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [f_cfg_w(WORD_WIDTH)-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [WORD_WIDTH-1:0]           i_cell_value,
    input  logic [WORD_WIDTH-1:0]           i_edge_left,
    input  logic [WORD_WIDTH-1:0]           i_edge_right,
    input  logic [WORD_WIDTH-1:0]           i_old_slope,
    input  logic                            i_last_cell,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [WORD_WIDTH-1:0]           o_out_slope,
    output logic                            o_out_final_result
);

    t_cmd    cmd;
    t_status status;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequence: load, left quotient, optional scaling, minmod and emit if there is a
    // predecessor, right quotient and its own emit on the last cell, then update the sweep state
    mmsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // operand registers, divider, alpha scaling, minmod and output register
    mmsl_datapath #(
        .WORD_WIDTH    (WORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cell_value       (i_cell_value),
        .i_edge_left        (i_edge_left),
        .i_edge_right       (i_edge_right),
        .i_old_slope        (i_old_slope),
        .i_last_cell        (i_last_cell),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_slope        (o_out_slope),
        .o_out_final_result (o_out_final_result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mmsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmsl_checker
    import mmsl_pkg::*;
#(
    parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [WORD_WIDTH-1:0] o_out_slope,
    input logic                  o_out_final_result
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_slope) && $stable(o_out_final_result))
        else $error("result payload changed while stalled");

    // one item at a time: no back-to-back accepts
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in work");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind minmod_slope_limiter mmsl_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_out_slope        (o_out_slope),
    .o_out_final_result (o_out_final_result)
);

`default_nettype wire

// ===== tb/minmod_slope_limiter_tb.sv =====
`timescale 1ns / 1ps

module minmod_slope_limiter_tb;
    import mmsl_pkg::*;

    localparam int W     = WORD_WIDTH_DEF;
    localparam int FB    = FRACTION_BITS_DEF;
    localparam int CFG_W = f_cfg_w(WORD_WIDTH_DEF);

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE     = 32'h0001_0000;

    // Index past the register file: a write here must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // Two quotients plus two alpha scalings and the minmod, with margin
    localparam int SETTLE_CYCLES = 160;
    localparam int RANDOM_CELLS  = 600;
    localparam int QUIET_CELLS   = 120;
    localparam int CYCLE_LIMIT   = 600_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [W-1:0]         i_cell_value;
    logic [W-1:0]         i_edge_left;
    logic [W-1:0]         i_edge_right;
    logic [W-1:0]         i_old_slope;
    logic                 i_last_cell;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [W-1:0]         o_out_slope;
    logic                 o_out_final_result;

    minmod_slope_limiter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cell_value       (i_cell_value),
        .i_edge_left        (i_edge_left),
        .i_edge_right       (i_edge_right),
        .i_old_slope        (i_old_slope),
        .i_last_cell        (i_last_cell),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_slope        (o_out_slope),
        .o_out_final_result (o_out_final_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [W-1:0] slope;
        logic         final_result;
    } t_slope_rec;

    // Slopes the sweep owes us, oldest first
    t_slope_rec pending_slopes[$];

    // Shadow of the register file
    logic [30:0]  reg_alpha;
    logic [W-1:0] reg_left_value;
    logic [W-1:0] reg_right_value;
    logic [30:0]  reg_left_spacing;
    logic [30:0]  reg_right_spacing;
    logic         reg_moving_grid;
    logic         reg_three_way;

    // Shadow of the sweep state: the cell seen last and its left quotient
    logic         sweep_open;
    logic [W-1:0] prev_value;
    logic [W-1:0] prev_edge_left;
    logic [W-1:0] prev_left_quot;
    logic [W-1:0] prev_old_slope;

    bit bursty;
    int errors;
    int cells_sent;
    int slopes_checked;
    int settings_used;
    int stall_left;
    int cycles;

    // ------------------------------------------------------------------
    // Slope arithmetic
    // ------------------------------------------------------------------

    function automatic longint sx(input logic [W-1:0] x);
        return longint'($signed(x));
    endfunction

    function automatic logic [63:0] word_mag(input logic [W-1:0] x);
        logic [W-1:0] m;
        m = x[W-1] ? -x : x;
        return 64'(m);
    endfunction

    // (num << FB) / den, truncated toward zero and clamped to the word range.
    // With halve set, den is a span and the spacing is half its magnitude.
    function automatic logic [W-1:0] sat_quotient(input longint num, input longint den,
                                                   input bit halve);
        logic [63:0] nm, dm, q, lim;
        bit          nneg, dneg, neg;
        nneg = num < 0;
        dneg = den < 0;
        nm   = nneg ? -num : num;
        dm   = dneg ? -den : den;
        if (halve)
            dm = dm >> 1;
        if (nm == 0)
            return '0;
        // Zero spacing: pin to the end of the range on the difference's side
        if (dm == 0)
            return nneg ? NEG_MIN : POS_MAX;
        neg = nneg ^ dneg;
        lim = neg ? 64'(NEG_MIN) : 64'(POS_MAX);
        q   = (nm << FB) / dm;
        if (q > lim)
            q = lim;
        return neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    function automatic logic [W-1:0] alpha_scale(input logic [W-1:0] p);
        logic [63:0] m, s, lim;
        m   = word_mag(p);
        lim = p[W-1] ? 64'(NEG_MIN) : 64'(POS_MAX);
        s   = (m * 64'(reg_alpha)) >> FB;
        if (s > lim)
            s = lim;
        return p[W-1] ? -s[W-1:0] : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] minmod_pair(input logic [W-1:0] a, input logic [W-1:0] b);
        if (a == 0 || b == 0 || a[W-1] != b[W-1])
            return '0;
        return (word_mag(a) <= word_mag(b)) ? a : b;
    endfunction

    function automatic logic [W-1:0] cell_slope(input logic [W-1:0] lq, input logic [W-1:0] rq,
                                                 input logic [W-1:0] old);
        if (reg_three_way)
            return minmod_pair(minmod_pair(alpha_scale(lq), alpha_scale(rq)), old);
        return minmod_pair(lq, rq);
    endfunction

    function automatic logic [W-1:0] edge_quotient(input logic [W-1:0] hi, input logic [W-1:0] lo,
                                                    input longint span);
        longint num;
        num = sx(hi) - sx(lo);
        if (reg_moving_grid)
            return sat_quotient(num, span, 1'b1);
        return sat_quotient(num, longint'(reg_left_spacing), 1'b0);
    endfunction

    // Advance the shadow sweep by one accepted cell; queue the slopes it owes
    task automatic advance_sweep(input logic [W-1:0] v, input logic [W-1:0] xl,
                                 input logic [W-1:0] xr, input logic [W-1:0] old,
                                 input logic last);
        logic [W-1:0] lq;
        logic [W-1:0] rq;
        longint       span;
        if (sweep_open) begin
            span = sx(xr) - sx(prev_edge_left);
            lq   = edge_quotient(v, prev_value, span);
            pending_slopes.push_back('{cell_slope(prev_left_quot, lq, prev_old_slope), 1'b0});
        end else begin
            span = sx(xr) - sx(xl) + longint'(reg_left_spacing);
            lq   = edge_quotient(v, reg_left_value, span);
        end
        if (last) begin
            span = sx(xr) - sx(xl) + longint'(reg_right_spacing);
            rq   = edge_quotient(reg_right_value, v, span);
            pending_slopes.push_back('{cell_slope(lq, rq, old), 1'b1});
            sweep_open     = 1'b0;
            prev_value     = '0;
            prev_edge_left = '0;
            prev_left_quot = '0;
            prev_old_slope = '0;
        end else begin
            sweep_open     = 1'b1;
            prev_value     = v;
            prev_edge_left = xl;
            prev_left_quot = lq;
            prev_old_slope = old;
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Send one cell. Valid stays high after acceptance so back-to-back items
    // need only one assignment per step; drop it only before a gap.
    task automatic push_cell(input logic [W-1:0] v, input logic [W-1:0] xl,
                             input logic [W-1:0] xr, input logic [W-1:0] old,
                             input logic last);
        if (bursty && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_value <= v;
        i_edge_left  <= xl;
        i_edge_right <= xr;
        i_old_slope  <= old;
        i_last_cell  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        cells_sent++;
        advance_sweep(v, xl, xr, old, last);
    endtask

    // Write one register; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ALPHA:         reg_alpha         = data[30:0];
            CFG_LEFT_VALUE:    reg_left_value    = data[W-1:0];
            CFG_RIGHT_VALUE:   reg_right_value   = data[W-1:0];
            CFG_LEFT_SPACING:  reg_left_spacing  = data[30:0];
            CFG_RIGHT_SPACING: reg_right_spacing = data[30:0];
            CFG_MOVING_GRID:   reg_moving_grid   = data[0];
            CFG_THREE_WAY:     reg_three_way     = data[0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Hold input, drain every owed slope, then let any quotient still in
    // flight for a first cell finish before touching the registers
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_slopes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return POS_MAX;
            1:       return NEG_MIN;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Roughly -8.0 .. +8.0, where slopes stay meaningful
    function automatic logic [W-1:0] small_word();
        return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
    endfunction

    function automatic logic [CFG_W-1:0] pick_spacing();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return ONE;
            2:       return 32'h7fff_ffff;
            3, 4:    return $urandom_range(1, 1 << 18);
            default: return $urandom_range(1, 32'h7fff_ffff);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_alpha();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return ONE;
            2:       return 32'h7fff_ffff;
            3:       return $urandom_range(0, 1 << 18);
            default: return $urandom & 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_boundary();
        return ($urandom_range(0, 2) == 0) ? rand_word() : small_word();
    endfunction

    task automatic shuffle_regs();
        write_reg(CFG_ALPHA, pick_alpha());
        write_reg(CFG_LEFT_VALUE, pick_boundary());
        write_reg(CFG_RIGHT_VALUE, pick_boundary());
        write_reg(CFG_LEFT_SPACING, pick_spacing());
        write_reg(CFG_RIGHT_SPACING, pick_spacing());
        write_reg(CFG_MOVING_GRID, $urandom_range(0, 1));
        write_reg(CFG_THREE_WAY, $urandom_range(0, 1));
        close_cfg();
    endtask

    // One sweep. Well-formed sweeps walk a real grid left to right; the
    // rest throw arbitrary edges and values at the block.
    task automatic run_sweep(input int len, input bit well_formed);
        logic [W-1:0] x, w, v, old, xl, xr;
        x = 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
        for (int i = 0; i < len; i++) begin
            if (well_formed) begin
                w   = ($urandom_range(0, 15) == 0) ? '0 : 32'($urandom_range(1, 1 << 18));
                xl  = x;
                xr  = x + w;
                x   = xr;
                v   = ($urandom_range(0, 5) == 0) ? rand_word() : small_word();
                old = ($urandom_range(0, 5) == 0) ? rand_word() : small_word();
            end else begin
                xl  = rand_word();
                xr  = rand_word();
                v   = rand_word();
                old = rand_word();
            end
            push_cell(v, xl, xr, old, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: fixed unit grid, plain minmod; extremes overflow the
    // quotient in both directions
    task automatic test_default_sweep();
        push_cell('0, '0, ONE, '0, 1'b0);
        push_cell(POS_MAX, '0, ONE, POS_MAX, 1'b0);
        push_cell(NEG_MIN, '0, ONE, NEG_MIN, 1'b0);
        push_cell(32'd1, '0, ONE, '0, 1'b1);
    endtask

    // A first cell marked last yields only its own slope
    task automatic test_single_cell();
        push_cell(-(5 * ONE), '0, ONE, ONE, 1'b1);
    endtask

    // Every register at an extreme, three-way limiting, plus a write to an
    // unmapped index that must be ignored
    task automatic test_register_extremes();
        settle_block();
        write_reg(CFG_ALPHA, 32'h7fff_ffff);
        write_reg(CFG_LEFT_VALUE, NEG_MIN);
        write_reg(CFG_RIGHT_VALUE, POS_MAX);
        write_reg(CFG_LEFT_SPACING, 32'd1);
        write_reg(CFG_RIGHT_SPACING, 32'h7fff_ffff);
        write_reg(CFG_MOVING_GRID, 32'd0);
        write_reg(CFG_THREE_WAY, 32'd1);
        write_reg(CFG_UNMAPPED, '1);
        close_cfg();
        push_cell(ONE, '0, ONE, POS_MAX, 1'b0);
        push_cell(-ONE, '0, ONE, NEG_MIN, 1'b0);
        push_cell(2 * ONE, '0, ONE, ONE, 1'b1);

        settle_block();
        write_reg(CFG_ALPHA, 32'd0);
        write_reg(CFG_LEFT_SPACING, 32'h7fff_ffff);
        close_cfg();
        push_cell(3 * ONE, '0, ONE, ONE, 1'b0);
        push_cell(-ONE, '0, ONE, ONE, 1'b1);
    endtask

    // Moving grid: normal span, zero span, huge span with zero difference,
    // span that halves to zero, and negative spans
    task automatic test_moving_grid();
        settle_block();
        write_reg(CFG_ALPHA, ONE);
        write_reg(CFG_LEFT_VALUE, 32'd0);
        write_reg(CFG_RIGHT_VALUE, 32'd0);
        write_reg(CFG_LEFT_SPACING, ONE);
        write_reg(CFG_RIGHT_SPACING, ONE);
        write_reg(CFG_MOVING_GRID, 32'd1);
        write_reg(CFG_THREE_WAY, 32'd0);
        close_cfg();
        push_cell(ONE, '0, ONE, '0, 1'b0);
        push_cell(3 * ONE, ONE, ONE, '0, 1'b0);
        push_cell(-(2 * ONE), ONE, ONE, '0, 1'b0);
        push_cell(-(2 * ONE), NEG_MIN, POS_MAX, '0, 1'b0);
        push_cell(5 * ONE, '0, NEG_MIN + 32'd1, '0, 1'b1);
        // Both boundary spans collapse to zero
        push_cell(7 * ONE, '0, -ONE, '0, 1'b1);
    endtask

    // Random register settings, each followed by a batch of sweeps; the
    // last stretch runs with both sides streaming
    task automatic test_random_sweeps();
        int start;
        int batch;
        int len;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS) begin
            bursty = (cells_sent - start) < (RANDOM_CELLS - QUIET_CELLS);
            settle_block();
            shuffle_regs();
            batch = cells_sent + $urandom_range(30, 60);
            while (cells_sent < batch) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
                run_sweep(len, $urandom_range(0, 6) != 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted slope, then pick the next ready
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            t_slope_rec exp_rec;
            slopes_checked++;
            if (pending_slopes.size() == 0) begin
                $error("unexpected result: slope %h final_result %b",
                       o_out_slope, o_out_final_result);
                errors++;
            end else begin
                exp_rec = pending_slopes.pop_front();
                if (o_out_slope !== exp_rec.slope) begin
                    $error("slope: expected %h, actual %h", exp_rec.slope, o_out_slope);
                    errors++;
                end
                if (o_out_final_result !== exp_rec.final_result) begin
                    $error("final_result: expected %b, actual %b",
                           exp_rec.final_result, o_out_final_result);
                    errors++;
                end
            end
        end
        if (stall_left != 0)
            stall_left--;
        else if (bursty && i_rst_n && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
        i_out_ready <= (stall_left == 0);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d slopes still owed",
                     cycles, pending_slopes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_cell_value = '0;
        i_edge_left  = '0;
        i_edge_right = '0;
        i_old_slope  = '0;
        i_last_cell  = 1'b0;
        i_out_ready  = 1'b0;

        reg_alpha         = ONE[30:0];
        reg_left_value    = '0;
        reg_right_value   = '0;
        reg_left_spacing  = ONE[30:0];
        reg_right_spacing = ONE[30:0];
        reg_moving_grid   = 1'b0;
        reg_three_way     = 1'b0;
        sweep_open        = 1'b0;
        prev_value        = '0;
        prev_edge_left    = '0;
        prev_left_quot    = '0;
        prev_old_slope    = '0;

        bursty         = 1'b1;
        errors         = 0;
        cells_sent     = 0;
        slopes_checked = 0;
        settings_used  = 1;
        stall_left     = 0;
        cycles         = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sweep();
        test_single_cell();
        test_register_extremes();
        test_moving_grid();
        test_random_sweeps();
        settle_block();

        $display("%0d cells in, %0d slopes checked, across %0d register settings",
                 cells_sent, slopes_checked, settings_used);
        $display("fixed and moving grids, two- and three-way minmod, saturating quotients");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
